### sv/hkcd_pkg.sv
// ----------------------------------------------------------------------------
// hkcd_pkg
// shared types, constants and the watched key table of the held key combo
// detector
// ----------------------------------------------------------------------------
`default_nettype none

package hkcd_pkg;

   // field widths
   localparam int TYPE_W    = 5;
   localparam int CODE_W    = 10;
   localparam int VALUE_W   = 2;
   localparam int PRESS_W   = 2;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   // watched key table
   localparam int NUM_KEYS_DEF = 8;
   localparam int MAX_SLOTS    = 16;

   localparam logic [CODE_W-1:0] KC_PWR    = 10'd116;
   localparam logic [CODE_W-1:0] KC_VOL_UP = 10'd115;
   localparam logic [CODE_W-1:0] KC_VOL_DN = 10'd114;
   localparam logic [CODE_W-1:0] KC_HOME   = 10'd172;
   localparam logic [CODE_W-1:0] KC_HOT    = 10'd252;
   localparam logic [CODE_W-1:0] KC_SOS    = 10'd672;
   localparam logic [CODE_W-1:0] KC_RETURN = 10'd158;
   localparam logic [CODE_W-1:0] KC_APPS   = 10'd254;
   localparam logic [CODE_W-1:0] NO_CODE   = 10'd1023;

   localparam logic [CODE_W-1:0] WATCHED_CODES [MAX_SLOTS] = '{
      KC_PWR, KC_VOL_UP, KC_VOL_DN, KC_HOME,
      KC_HOT, KC_SOS, KC_RETURN, KC_APPS,
      NO_CODE, NO_CODE, NO_CODE, NO_CODE,
      NO_CODE, NO_CODE, NO_CODE, NO_CODE
   };

   // event decoding
   localparam logic [TYPE_W-1:0]  EVT_KEY     = 5'd1;
   localparam logic [CODE_W-1:0]  CODE_LIMIT  = 10'd767;
   localparam logic [VALUE_W-1:0] VALUE_PRESS = 2'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_KEY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_KEY      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PRESSES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_KEY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_PRESSES = 3'd4;

   // configuration reset values
   localparam logic [CODE_W-1:0]  ANCHOR_KEY_RST     = 10'd116;
   localparam logic [CODE_W-1:0]  FIRST_KEY_RST      = 10'd115;
   localparam logic [PRESS_W-1:0] FIRST_PRESSES_RST  = 2'd1;
   localparam logic [CODE_W-1:0]  SECOND_KEY_RST     = 10'd114;
   localparam logic [PRESS_W-1:0] SECOND_PRESSES_RST = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0]  anchor_key;
      logic [CODE_W-1:0]  first_key;
      logic [PRESS_W-1:0] first_presses;
      logic [CODE_W-1:0]  second_key;
      logic [PRESS_W-1:0] second_presses;
   } cfg_type;

   // decoded event class handed from lookup to update
   typedef struct packed {
      logic hit;        // watched key event
      logic is_press;
      logic is_hold;
      logic is_first;
      logic is_second;
   } evt_class_type;

endpackage

`default_nettype wire

### sv/hkcd_lookup.sv
// ----------------------------------------------------------------------------
// hkcd_lookup
// matches the key code of an event against the watched key table and the
// configured combination keys
// ----------------------------------------------------------------------------
`default_nettype none

module hkcd_lookup #(
   parameter int NUM_KEYS = hkcd_pkg::NUM_KEYS_DEF,
   parameter int IDX_W    = $clog2(NUM_KEYS)
) (
   input  wire logic [hkcd_pkg::TYPE_W-1:0]  evt_kind,
   input  wire logic [hkcd_pkg::CODE_W-1:0]  scan_code,
   input  wire logic [hkcd_pkg::VALUE_W-1:0] key_value,
   input  wire hkcd_pkg::cfg_type            cfg,
   output hkcd_pkg::evt_class_type           evt_class,
   output logic [IDX_W-1:0]                  slot_idx
);

   logic             any_match;
   logic [IDX_W-1:0] first_idx;

   // lowest matching slot wins
   always_comb begin
      any_match = 1'b0;
      first_idx = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (hkcd_pkg::WATCHED_CODES[i] == scan_code) begin
            any_match = 1'b1;
            first_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      evt_class.hit       = (evt_kind == hkcd_pkg::EVT_KEY) &&
                            (scan_code < hkcd_pkg::CODE_LIMIT) && any_match;
      evt_class.is_press  = (key_value == hkcd_pkg::VALUE_PRESS);
      evt_class.is_hold   = (scan_code == cfg.anchor_key);
      evt_class.is_first  = (scan_code == cfg.first_key);
      evt_class.is_second = (scan_code == cfg.second_key);
   end

   assign slot_idx = first_idx;

endmodule

`default_nettype wire

### sv/hkcd_update.sv
// ----------------------------------------------------------------------------
// hkcd_update
// key state, combination counter and result register
// ----------------------------------------------------------------------------
`default_nettype none

module hkcd_update #(
   parameter int NUM_KEYS = hkcd_pkg::NUM_KEYS_DEF,
   parameter int IDX_W    = $clog2(NUM_KEYS)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire hkcd_pkg::evt_class_type       evt_class,
   input  wire logic [IDX_W-1:0]              slot_idx,
   input  wire hkcd_pkg::cfg_type             cfg,
   output logic                               dump_request,
   output logic                               stage,
   output logic [hkcd_pkg::COUNT_W-1:0]       press_total
);

   localparam int CW = hkcd_pkg::COUNT_W;

   logic [NUM_KEYS-1:0] key_is_down_ff, key_is_down_in;
   logic                hold_is_down_ff, hold_is_down_in;
   logic [CW-1:0]       match_count_ff, match_count_in;
   logic                combo_stage_ff, combo_stage_in;
   logic                dump_ff, dump_in;

   logic [CW-1:0] first_need;
   logic [CW-1:0] second_need;
   logic [CW-1:0] total_need;
   logic [CW-1:0] stage_need;
   logic          already_down;
   logic          want_hit;

   // a press count of zero counts as one
   assign first_need  = (cfg.first_presses == '0) ? CW'(1) : CW'(cfg.first_presses);
   assign second_need = (cfg.second_presses == '0) ? CW'(1) : CW'(cfg.second_presses);
   assign total_need  = first_need + second_need;

   always_comb begin
      key_is_down_in  = key_is_down_ff;
      hold_is_down_in = hold_is_down_ff;
      match_count_in  = match_count_ff;
      combo_stage_in  = combo_stage_ff;
      dump_in         = 1'b0;
      stage_need      = first_need;
      already_down    = evt_class.is_hold ? hold_is_down_ff : key_is_down_ff[slot_idx];
      want_hit        = combo_stage_ff ? evt_class.is_second : evt_class.is_first;

      if (evt_class.hit) begin
         if (evt_class.is_press) begin
            if (!already_down) begin
               key_is_down_in[slot_idx] = 1'b1;
               if (evt_class.is_hold) begin
                  hold_is_down_in = 1'b1;
               end else if (hold_is_down_ff) begin
                  if (want_hit) begin
                     if (match_count_ff < total_need - CW'(1)) begin
                        match_count_in = match_count_ff + CW'(1);
                     end else begin
                        dump_in = 1'b1;
                     end
                  end else begin
                     match_count_in = '0;
                     combo_stage_in = 1'b0;
                  end
                  stage_need = combo_stage_in ? total_need : first_need;
                  if (match_count_in == stage_need) begin
                     if (!combo_stage_in) begin
                        combo_stage_in = 1'b1;
                     end else begin
                        dump_in = 1'b1;
                     end
                  end
               end
            end
         end else begin
            key_is_down_in[slot_idx] = 1'b0;
            if (evt_class.is_hold) begin
               hold_is_down_in = 1'b0;
               combo_stage_in  = 1'b0;
               match_count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_is_down_ff  <= '0;
         hold_is_down_ff <= 1'b0;
         match_count_ff  <= '0;
         combo_stage_ff  <= 1'b0;
      end else if (advance) begin
         key_is_down_ff  <= key_is_down_in;
         hold_is_down_ff <= hold_is_down_in;
         match_count_ff  <= match_count_in;
         combo_stage_ff  <= combo_stage_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         dump_ff <= dump_in;
      end
   end

   assign dump_request = dump_ff;
   assign stage        = combo_stage_ff;
   assign press_total  = match_count_ff;

endmodule

`default_nettype wire

### sv/held_key_combo_detector_unit.sv
// ----------------------------------------------------------------------------
// held_key_combo_detector_unit
// detects a combination of key presses made while a hold key is down
// ----------------------------------------------------------------------------
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   req     | req_valid/ready, evt_kind, scan_code, value | in
//   rsp     | rsp_valid/ready, dump_request, stage,     | out
//           | press_total                               |
//   csr     | csr_wr_en, csr_index, csr_wdata            | in
//
// one item per cycle sustained while rsp_ready stays high; an item waits in the input
// register and then moves into the result register and out at the rsp port
// rsp valid rises once an accepted item has moved from the input register into the result register
// reset clears the key state, counter, stage and config to defaults
// a stalled rsp holds its item while the input register still takes one more
// ----------------------------------------------------------------------------
`default_nettype none

module held_key_combo_detector_unit #(
   parameter int NUM_KEYS = hkcd_pkg::NUM_KEYS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [hkcd_pkg::TYPE_W-1:0]       req_evt_kind,
   input  wire logic [hkcd_pkg::CODE_W-1:0]       req_scan_code,
   input  wire logic [hkcd_pkg::VALUE_W-1:0]      req_key_value,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_dump_request,
   output logic                                   rsp_stage,
   output logic [hkcd_pkg::COUNT_W-1:0]           rsp_press_total,
   // configuration writes
   input  wire logic                              csr_wr_en,
   input  wire logic [hkcd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [hkcd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(NUM_KEYS);

   // config registers
   hkcd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.anchor_key     <= hkcd_pkg::ANCHOR_KEY_RST;
         cfg_ff.first_key      <= hkcd_pkg::FIRST_KEY_RST;
         cfg_ff.first_presses  <= hkcd_pkg::FIRST_PRESSES_RST;
         cfg_ff.second_key     <= hkcd_pkg::SECOND_KEY_RST;
         cfg_ff.second_presses <= hkcd_pkg::SECOND_PRESSES_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            hkcd_pkg::CSR_ANCHOR_KEY: begin
               cfg_ff.anchor_key <= csr_wdata;
            end
            hkcd_pkg::CSR_FIRST_KEY: begin
               cfg_ff.first_key <= csr_wdata;
            end
            hkcd_pkg::CSR_FIRST_PRESSES: begin
               cfg_ff.first_presses <= csr_wdata[hkcd_pkg::PRESS_W-1:0];
            end
            hkcd_pkg::CSR_SECOND_KEY: begin
               cfg_ff.second_key <= csr_wdata;
            end
            hkcd_pkg::CSR_SECOND_PRESSES: begin
               cfg_ff.second_presses <= csr_wdata[hkcd_pkg::PRESS_W-1:0];
            end
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // input register and result register handshake
   logic                              in_valid_ff;
   logic                              rsp_valid_ff;
   logic                              advance;
   logic [hkcd_pkg::TYPE_W-1:0]       evt_kind_ff;
   logic [hkcd_pkg::CODE_W-1:0]       scan_code_ff;
   logic [hkcd_pkg::VALUE_W-1:0]      key_value_ff;

   // item moves to the result register when that slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         evt_kind_ff  <= req_evt_kind;
         scan_code_ff <= req_scan_code;
         key_value_ff <= req_key_value;
      end
   end

   // classify the held item
   hkcd_pkg::evt_class_type evt_class;
   logic [IDX_W-1:0]        slot_idx;

   hkcd_lookup #(
      .NUM_KEYS (NUM_KEYS),
      .IDX_W    (IDX_W)
   ) u_lookup (
      .evt_kind   (evt_kind_ff),
      .scan_code  (scan_code_ff),
      .key_value  (key_value_ff),
      .cfg        (cfg_ff),
      .evt_class  (evt_class),
      .slot_idx   (slot_idx)
   );

   // state update and result register
   hkcd_update #(
      .NUM_KEYS (NUM_KEYS),
      .IDX_W    (IDX_W)
   ) u_update (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .evt_class    (evt_class),
      .slot_idx     (slot_idx),
      .cfg          (cfg_ff),
      .dump_request (rsp_dump_request),
      .stage        (rsp_stage),
      .press_total  (rsp_press_total)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### dv/hkcd_combo_checker.sv
// ----------------------------------------------------------------------------
// hkcd_combo_checker
// watches the req, rsp and csr ports of the held key combo detector, keeps
// its own copy of the key state and settings and checks every result item
// ----------------------------------------------------------------------------

module hkcd_combo_checker #(
   parameter int NUM_KEYS = hkcd_pkg::NUM_KEYS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [hkcd_pkg::TYPE_W-1:0]       req_evt_kind,
   input  logic [hkcd_pkg::CODE_W-1:0]       req_scan_code,
   input  logic [hkcd_pkg::VALUE_W-1:0]      req_key_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_dump_request,
   input  logic                              rsp_stage,
   input  logic [hkcd_pkg::COUNT_W-1:0]      rsp_press_total,
   input  logic                              csr_wr_en,
   input  logic [hkcd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hkcd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatches,
   output int                                pending_results
);
   import hkcd_pkg::*;

   typedef struct packed {
      logic               dump_request;
      logic               stage;
      logic [COUNT_W-1:0] press_total;
   } combo_outcome_type;

   cfg_type              cfg;
   logic [MAX_SLOTS-1:0] key_down;
   logic                 hold_down;
   logic [COUNT_W-1:0]   press_count;
   logic                 second_stage;
   combo_outcome_type    awaited_outcomes[$];
   int                   rsp_seen;

   initial begin
      mismatches      = 0;
      pending_results = 0;
      rsp_seen        = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t combo check, result %0d: %s", $time, rsp_seen, msg);
      mismatches++;
   endtask

   // one event through the combo state, returns the result it should give
   function automatic combo_outcome_type apply_event(input logic [TYPE_W-1:0]  etype,
                                                     input logic [CODE_W-1:0]  code,
                                                     input logic [VALUE_W-1:0] value);
      combo_outcome_type outcome;
      int                slot;
      int                first_need;
      int                total_need;
      int                need;
      logic              is_hold;
      logic              was_down;
      logic              dump;
      logic [CODE_W-1:0] wanted;
      slot = -1;
      dump = 1'b0;
      if (etype == EVT_KEY && code < CODE_LIMIT) begin
         for (int i = 0; i < NUM_KEYS && i < MAX_SLOTS; i++) begin
            if (slot < 0 && WATCHED_CODES[i] == code) slot = i;
         end
      end
      if (slot >= 0) begin
         is_hold = (code == cfg.anchor_key);
         if (value == VALUE_PRESS) begin
            was_down = is_hold ? hold_down : key_down[slot];
            if (!was_down) begin
               key_down[slot] = 1'b1;
               if (is_hold) begin
                  hold_down = 1'b1;
               end else if (hold_down) begin
                  // a count of zero behaves as one
                  first_need = (cfg.first_presses == '0) ? 1 : int'(cfg.first_presses);
                  total_need = first_need +
                     ((cfg.second_presses == '0) ? 1 : int'(cfg.second_presses));
                  wanted = second_stage ? cfg.second_key : cfg.first_key;
                  if (code == wanted) begin
                     if (press_count < total_need - 1) press_count = press_count + 1'b1;
                     else dump = 1'b1;
                  end else begin
                     press_count  = '0;
                     second_stage = 1'b0;
                  end
                  need = second_stage ? total_need : first_need;
                  if (press_count == need) begin
                     if (!second_stage) second_stage = 1'b1;
                     else dump = 1'b1;
                  end
               end
            end
         end else begin
            key_down[slot] = 1'b0;
            if (is_hold) begin
               hold_down    = 1'b0;
               second_stage = 1'b0;
               press_count  = '0;
            end
         end
      end
      outcome.dump_request = dump;
      outcome.stage        = second_stage;
      outcome.press_total  = press_count;
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      combo_outcome_type want;
      if (reset) begin
         cfg.anchor_key     = ANCHOR_KEY_RST;
         cfg.first_key      = FIRST_KEY_RST;
         cfg.first_presses  = FIRST_PRESSES_RST;
         cfg.second_key     = SECOND_KEY_RST;
         cfg.second_presses = SECOND_PRESSES_RST;
         key_down           = '0;
         hold_down          = 1'b0;
         press_count        = '0;
         second_stage       = 1'b0;
         awaited_outcomes.delete();
      end else begin
         // result side first: it always belongs to an older item
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("result item with nothing awaited");
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_dump_request !== want.dump_request)
                  report_mismatch($sformatf("dump_request %b, expected %b",
                                            rsp_dump_request, want.dump_request));
               if (rsp_stage !== want.stage)
                  report_mismatch($sformatf("stage %b, expected %b",
                                            rsp_stage, want.stage));
               if (rsp_press_total !== want.press_total)
                  report_mismatch($sformatf("press_total %0d, expected %0d",
                                            rsp_press_total, want.press_total));
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_event(req_evt_kind, req_scan_code,
                                                   req_key_value));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ANCHOR_KEY:     cfg.anchor_key     = csr_wdata;
               CSR_FIRST_KEY:      cfg.first_key      = csr_wdata;
               CSR_FIRST_PRESSES:  cfg.first_presses  = csr_wdata[PRESS_W-1:0];
               CSR_SECOND_KEY:     cfg.second_key     = csr_wdata;
               CSR_SECOND_PRESSES: cfg.second_presses = csr_wdata[PRESS_W-1:0];
               default: ;
            endcase
         end
      end
      pending_results = awaited_outcomes.size();
   end

endmodule

### dv/tb_held_key_combo_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_held_key_combo_detector_unit
// drives key events into the held key combo detector under random sender
// gaps and receiver stalls, walks through several register settings and
// leaves all result checking to hkcd_combo_checker
// ----------------------------------------------------------------------------

module tb_held_key_combo_detector_unit;
   import hkcd_pkg::*;

   localparam int ITEM_TARGET = 1150;    // handled key events to send
   localparam int NUM_PHASES  = 10;      // register settings walked through
   localparam int CYCLE_LIMIT = 200000;  // watchdog, far above a slow run
   localparam int DRAIN_WAIT  = 8;       // cycles after the last result

   // an index the block has no register for
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   // key values besides press
   localparam logic [VALUE_W-1:0] VALUE_RELEASE = 2'd0;
   localparam logic [VALUE_W-1:0] VALUE_REPEAT  = 2'd2;
   localparam logic [VALUE_W-1:0] VALUE_OTHER   = 2'd3;

   // some event type that is not a key event
   localparam logic [TYPE_W-1:0] EVT_SYNC = 5'd0;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_COIN, READY_SPARSE} stall_mode_type;

   // every input is known from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [TYPE_W-1:0]     req_evt_kind   = '0;
   logic [CODE_W-1:0]     req_scan_code  = '0;
   logic [VALUE_W-1:0]    req_key_value  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic                  rsp_dump_request;
   logic                  rsp_stage;
   logic [COUNT_W-1:0]    rsp_press_total;
   logic                  csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   int             mismatches;
   int             pending_results;
   int             req_accepted = 0;   // item count taken on the req side
   int             cycle_count  = 0;
   int             key_items    = 0;   // key events sent, used to stop stimulus
   int             burst_left   = 0;   // items left before the next sender gap
   stall_mode_type stall_mode   = READY_ALWAYS;
   int             stall_left   = 0;
   cfg_type        cur_cfg;            // last settings written, shapes the combos

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   held_key_combo_detector_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_evt_kind     (req_evt_kind),
      .req_scan_code    (req_scan_code),
      .req_key_value    (req_key_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dump_request (rsp_dump_request),
      .rsp_stage        (rsp_stage),
      .rsp_press_total  (rsp_press_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   hkcd_combo_checker #(
      .NUM_KEYS (NUM_KEYS_DEF)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_evt_kind     (req_evt_kind),
      .req_scan_code    (req_scan_code),
      .req_key_value    (req_key_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dump_request (rsp_dump_request),
      .rsp_stage        (rsp_stage),
      .rsp_press_total  (rsp_press_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .pending_results  (pending_results)
   );

   // req handshakes counted at the edge, read back at the falling edge
   always @(posedge clock) begin
      if (reset) req_accepted <= 0;
      else if (req_valid && req_ready) req_accepted <= req_accepted + 1;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: stretches of always ready, light and heavy random stalls,
   // and a sparse pattern keyed to the watchdog cycle counter
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_COIN:   rsp_ready <= ($urandom_range(0, 1) != 0);
         default:      rsp_ready <= (cycle_count % 5 == 0);
      endcase
   end

   function automatic logic [CODE_W-1:0] any_watched();
      return WATCHED_CODES[$urandom_range(0, NUM_KEYS_DEF - 1)];
   endfunction

   // any value but press counts as a release
   function automatic logic [VALUE_W-1:0] release_value();
      logic [VALUE_W-1:0] v;
      v = VALUE_W'($urandom);
      return (v == VALUE_PRESS) ? VALUE_RELEASE : v;
   endfunction

   // sender pacing: bursts of random length, then a short gap with valid low
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // one item: valid stays up with a steady payload until it is taken
   task automatic send_event(input logic [TYPE_W-1:0]  etype,
                             input logic [CODE_W-1:0]  code,
                             input logic [VALUE_W-1:0] value);
      int target;
      target = req_accepted + 1;
      req_valid     <= 1'b1;
      req_evt_kind  <= etype;
      req_scan_code <= code;
      req_key_value <= value;
      do @(negedge clock); while (req_accepted != target);
      if (etype == EVT_KEY) key_items++;
      pace_sender();
   endtask

   // events the block should mostly ignore, plus stray watched key traffic
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_event(TYPE_W'($urandom), CODE_W'($urandom), VALUE_W'($urandom));
         1: send_event(EVT_KEY, any_watched(), VALUE_W'($urandom));
         2: send_event(EVT_KEY, CODE_W'($urandom_range(CODE_LIMIT, 1023)), VALUE_PRESS);
         default: send_event(TYPE_W'($urandom), any_watched(), VALUE_PRESS);
      endcase
   endtask

   // press and usually release one key, with the odd wrong key or stray
   // event in front; a key left down makes its next press a no-op
   task automatic tap_key(input logic [CODE_W-1:0] code);
      if ($urandom_range(0, 9) == 0) send_noise();
      if ($urandom_range(0, 11) == 0) begin
         send_event(EVT_KEY, any_watched(), VALUE_PRESS);
         send_event(EVT_KEY, any_watched(), release_value());
      end
      send_event(EVT_KEY, code, VALUE_PRESS);
      if ($urandom_range(0, 7) != 0) send_event(EVT_KEY, code, release_value());
   endtask

   // one attempt at the combination under the current settings
   task automatic play_combo();
      int first_n;
      int second_n;
      first_n  = (cur_cfg.first_presses == '0) ? 1 : int'(cur_cfg.first_presses);
      if ($urandom_range(0, 3) == 0) first_n = $urandom_range(0, 3);
      second_n = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) send_event(EVT_KEY, cur_cfg.anchor_key, release_value());
      if ($urandom_range(0, 9) != 0) send_event(EVT_KEY, cur_cfg.anchor_key, VALUE_PRESS);
      repeat (first_n) tap_key(cur_cfg.first_key);
      repeat (second_n) tap_key(cur_cfg.second_key);
      if ($urandom_range(0, 2) != 0) send_event(EVT_KEY, cur_cfg.anchor_key, release_value());
   endtask

   // let every result come back before touching the registers
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // all five registers, press counts with junk in the unused upper bits
   task automatic program_config(input cfg_type c);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      write_csr(CSR_ANCHOR_KEY, c.anchor_key);
      write_csr(CSR_FIRST_KEY, c.first_key);
      write_csr(CSR_FIRST_PRESSES, {(CSR_DATA_W - PRESS_W)'($urandom), c.first_presses});
      write_csr(CSR_SECOND_KEY, c.second_key);
      write_csr(CSR_SECOND_PRESSES, {(CSR_DATA_W - PRESS_W)'($urandom), c.second_presses});
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   // early phases pin the corner settings, the rest are random
   function automatic cfg_type phase_config(input int phase);
      cfg_type c;
      c.anchor_key     = any_watched();
      c.first_key      = any_watched();
      c.second_key     = any_watched();
      c.first_presses  = PRESS_W'($urandom);
      c.second_presses = PRESS_W'($urandom);
      case (phase)
         1: begin
            // longest combination
            c.anchor_key     = KC_HOME;
            c.first_key      = KC_RETURN;
            c.second_key     = KC_APPS;
            c.first_presses  = '1;
            c.second_presses = '1;
         end
         2: begin
            // zero counts behave as one
            c.anchor_key     = KC_HOT;
            c.first_key      = KC_SOS;
            c.second_key     = KC_PWR;
            c.first_presses  = '0;
            c.second_presses = '0;
         end
         3: c.anchor_key = '1;                // hold key not watched, nothing counts
         4: c.first_key = c.anchor_key;       // first stage key is the hold key
         5: c.second_key = c.first_key;       // same key for both stages
         6: c.first_key = '0;                 // first stage key not watched
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cur_cfg.anchor_key     = ANCHOR_KEY_RST;
      cur_cfg.first_key      = FIRST_KEY_RST;
      cur_cfg.first_presses  = FIRST_PRESSES_RST;
      cur_cfg.second_key     = SECOND_KEY_RST;
      cur_cfg.second_presses = SECOND_PRESSES_RST;

      // hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk with the reset settings: hold power, one volume up,
      // then volume down twice
      send_event(EVT_KEY, KC_VOL_DN, VALUE_PRESS);         // hold up, nothing counts
      send_event(EVT_KEY, KC_VOL_DN, VALUE_RELEASE);
      send_event(EVT_KEY, KC_PWR, VALUE_PRESS);            // hold goes down
      send_event(EVT_KEY, KC_PWR, VALUE_PRESS);            // already down
      send_event(EVT_KEY, KC_VOL_UP, VALUE_PRESS);         // first stage done
      send_event(EVT_KEY, KC_VOL_UP, VALUE_REPEAT);        // autorepeat is a release
      send_event(EVT_KEY, KC_VOL_DN, VALUE_PRESS);
      send_event(EVT_KEY, KC_VOL_DN, VALUE_PRESS);         // still down, no count
      send_event(EVT_KEY, KC_VOL_DN, VALUE_OTHER);
      send_event(EVT_KEY, KC_VOL_DN, VALUE_PRESS);         // completes, dump pulse
      send_event(EVT_KEY, KC_VOL_DN, VALUE_RELEASE);
      send_event(EVT_KEY, KC_VOL_DN, VALUE_PRESS);         // further match, dump again
      send_event(EVT_SYNC, KC_HOME, VALUE_PRESS);          // not a key event
      send_event('1, '1, VALUE_OTHER);                     // every field at its top
      send_event(EVT_KEY, CODE_LIMIT, VALUE_PRESS);        // first rejected code
      send_event(EVT_KEY, CODE_LIMIT - 1'b1, VALUE_PRESS); // in range, not watched
      send_event(EVT_KEY, '0, VALUE_PRESS);
      send_event(EVT_KEY, KC_HOME, VALUE_PRESS);           // wrong key restarts
      send_event(EVT_KEY, KC_HOME, VALUE_RELEASE);
      send_event(EVT_KEY, KC_VOL_UP, VALUE_PRESS);         // first stage again
      send_event(EVT_KEY, KC_HOT, VALUE_PRESS);            // wrong key in the second stage
      send_event(EVT_KEY, KC_PWR, VALUE_RELEASE);          // hold release clears all
      send_event(EVT_KEY, KC_SOS, VALUE_PRESS);            // hold up, only marks down
      send_event(EVT_KEY, KC_SOS, VALUE_RELEASE);

      // random part, one settings phase after another
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain_results();
            program_config(phase_config(phase));
         end
         while (key_items < (phase + 1) * ITEM_TARGET / NUM_PHASES) begin
            if ($urandom_range(0, 6) == 0) send_noise();
            else play_combo();
         end
      end

      drain_results();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
